[src/thq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thq_pkg
// Shared types, widths and constants of the terrain height query block.
// ----------------------------------------------------------------------------
package thq_pkg;

  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 65536;
  localparam int HEIGHT_W    = 8;
  localparam int POS_W       = 20;
  localparam int SP_W        = 16;
  localparam int VERT_W      = 9;
  localparam int SURF_W      = 14;
  localparam int MAX_SIDE    = 256;

  localparam logic [VERT_W-1:0] VERT_RESET = 9'd129;
  localparam logic [SP_W-1:0]   SP_RESET   = 16'd256;

  // q2.12 offset of one half
  localparam logic [SURF_W-1:0] HALF_Q12 = 14'd2048;

  // register indexes on the configuration port
  localparam logic [1:0] REG_VERTICES_X = 2'd0;
  localparam logic [1:0] REG_VERTICES_Z = 2'd1;
  localparam logic [1:0] REG_GRID_SPACING = 2'd2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

endpackage
`default_nettype wire

[src/thq_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thq_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
module thq_div #(
  parameter int DVD_W = 20,
  parameter int DSR_W = 16,
  parameter int QUO_W = 20,
  parameter int SB_W  = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire logic [DVD_W-1:0] in_dvd,
  input  wire logic [DSR_W-1:0] divisor,
  input  wire logic [SB_W-1:0]  in_sb,
  output logic                  out_vld,
  output logic [QUO_W-1:0]      out_quo,
  output logic [DSR_W-1:0]      out_rem,
  output logic [SB_W-1:0]       out_sb
);

  logic             vld_r [QUO_W];
  logic [DSR_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [DVD_W-1:0] dvd_r [QUO_W];
  logic [SB_W-1:0]  sb_r  [QUO_W];

  logic [DSR_W-1:0] rem_first;

  // upper dividend bits already stand below the divisor
  generate
    if (DVD_W > QUO_W) begin : g_pre
      assign rem_first = DSR_W'(in_dvd[DVD_W-1:QUO_W]);
    end else begin : g_nopre
      assign rem_first = '0;
    end
  endgenerate

  for (genvar i = 0; i < QUO_W; i++) begin : g_st
    logic             vld_in;
    logic [DSR_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [DVD_W-1:0] dvd_in;
    logic [SB_W-1:0]  sb_in;
    logic [DSR_W:0]   trial;
    logic             ge;

    if (i == 0) begin : g_head
      assign vld_in = in_vld;
      assign rem_in = rem_first;
      assign quo_in = '0;
      assign dvd_in = in_dvd;
      assign sb_in  = in_sb;
    end else begin : g_body
      assign vld_in = vld_r[i-1];
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
      assign dvd_in = dvd_r[i-1];
      assign sb_in  = sb_r[i-1];
    end

    assign trial = {rem_in, dvd_in[QUO_W-1-i]};
    assign ge    = (trial >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      rem_r[i] <= ge ? DSR_W'(trial - {1'b0, divisor}) : DSR_W'(trial);
      quo_r[i] <= {quo_in[QUO_W-2:0], ge};
      dvd_r[i] <= dvd_in;
      sb_r[i]  <= sb_in;
    end
  end

  assign out_vld = vld_r[QUO_W-1];
  assign out_quo = quo_r[QUO_W-1];
  assign out_rem = rem_r[QUO_W-1];
  assign out_sb  = sb_r[QUO_W-1];

endmodule
`default_nettype wire

[src/thq_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thq_store
// Height sample store split into even and odd address banks; reads the four
// corners of a cell together, two per bank.
// ----------------------------------------------------------------------------
module thq_store (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [thq_pkg::ADDR_W-1:0]    wr_addr,
  input  wire logic [thq_pkg::HEIGHT_W-1:0]  wr_data,
  input  wire logic [thq_pkg::ADDR_W-1:0]    rd_near,
  input  wire logic [thq_pkg::ADDR_W-1:0]    rd_far,
  output logic [thq_pkg::HEIGHT_W-1:0]       smp_d,
  output logic [thq_pkg::HEIGHT_W-1:0]       smp_c,
  output logic [thq_pkg::HEIGHT_W-1:0]       smp_a,
  output logic [thq_pkg::HEIGHT_W-1:0]       smp_b
);

  localparam int BANK_D = thq_pkg::STORE_DEPTH / 2;
  localparam int IDX_W  = thq_pkg::ADDR_W - 1;
  localparam int HW     = thq_pkg::HEIGHT_W;

  logic [HW-1:0] even_mem [BANK_D];
  logic [HW-1:0] odd_mem  [BANK_D];

  logic [thq_pkg::ADDR_W:0] near_p1;
  logic [thq_pkg::ADDR_W:0] far_p1;
  logic [IDX_W-1:0]         ev_near_idx, od_near_idx, ev_far_idx, od_far_idx;

  logic [HW-1:0] ev_near_r, od_near_r, ev_far_r, od_far_r;
  logic          par_near_r, par_far_r;

  // a pair at p sits at even index (p+1)/2 and odd index p/2
  assign near_p1     = {1'b0, rd_near} + 1'b1;
  assign far_p1      = {1'b0, rd_far} + 1'b1;
  assign ev_near_idx = near_p1[IDX_W:1];
  assign od_near_idx = rd_near[IDX_W:1];
  assign ev_far_idx  = far_p1[IDX_W:1];
  assign od_far_idx  = rd_far[IDX_W:1];

  always_ff @(posedge clk) begin
    if (wr_en && !wr_addr[0]) begin
      even_mem[wr_addr[IDX_W:1]] <= wr_data;
    end
    ev_near_r <= even_mem[ev_near_idx];
    ev_far_r  <= even_mem[ev_far_idx];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_addr[0]) begin
      odd_mem[wr_addr[IDX_W:1]] <= wr_data;
    end
    od_near_r <= odd_mem[od_near_idx];
    od_far_r  <= odd_mem[od_far_idx];
  end

  always_ff @(posedge clk) begin
    par_near_r <= rd_near[0];
    par_far_r  <= rd_far[0];
  end

  assign smp_d = par_near_r ? od_near_r : ev_near_r;
  assign smp_c = par_near_r ? ev_near_r : od_near_r;
  assign smp_a = par_far_r  ? od_far_r  : ev_far_r;
  assign smp_b = par_far_r  ? ev_far_r  : od_far_r;

endmodule
`default_nettype wire

[src/terrain_height_query.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// terrain_height_query
// Height-field lookup: loads 8-bit samples and interpolates query heights.
// ----------------------------------------------------------------------------
// usage:
//   an item is taken at a clock edge with start high and busy low; busy stays
//   low, so one item may be given every cycle. in_op selects a load (writes
//   in_height_byte at in_vertex_address) or a query (in_query_x, in_query_z).
//   each query gives one result, shown for one cycle with out_valid high;
//   loads give none. results leave in item order.
//   the path from the accepting edge to out_valid runs through 20 stages of
//   the cell divider, address, memory read, weighting, sum, 14 stages of the
//   output divider and the output register.
//   throughput is one item per cycle; the sample memory has two banks with
//   two read ports each, so the four cell corners come in one access.
//   loads write at the same pipeline stage where queries read, so order holds.
//   the receiver cannot stall the result channel.
//   reset clears the pipeline and sets vertices_x, vertices_z to 129 and
//   grid_spacing to 256; the sample store is not cleared and must be loaded
//   before queries touch it. configuration must be written over the apb port
//   only while no item is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module terrain_height_query (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_op,
  input  wire logic [thq_pkg::ADDR_W-1:0]    in_vertex_address,
  input  wire logic [thq_pkg::HEIGHT_W-1:0]  in_height_byte,
  input  wire logic [thq_pkg::POS_W-1:0]     in_query_x,
  input  wire logic [thq_pkg::POS_W-1:0]     in_query_z,
  output logic                               out_valid,
  output logic [thq_pkg::SURF_W-1:0]         out_surface_height,
  output logic                               out_off_grid,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int AW   = thq_pkg::ADDR_W;
  localparam int HW   = thq_pkg::HEIGHT_W;
  localparam int PW   = thq_pkg::POS_W;
  localparam int SW   = thq_pkg::SP_W;
  localparam int VW   = thq_pkg::VERT_W;
  localparam int BW   = 2 * VW + 1;
  localparam int NW   = 24;
  localparam int XW   = 38;
  localparam int DW   = 24;
  localparam int QW   = 14;

  // configuration registers
  logic [VW-1:0] vx_r, vz_r;
  logic [SW-1:0] sp_r;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= thq_pkg::VERT_RESET;
      vz_r <= thq_pkg::VERT_RESET;
      sp_r <= thq_pkg::SP_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        thq_pkg::REG_VERTICES_X:   vx_r <= pwdata[VW-1:0];
        thq_pkg::REG_VERTICES_Z:   vz_r <= pwdata[VW-1:0];
        thq_pkg::REG_GRID_SPACING: sp_r <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      thq_pkg::REG_VERTICES_X:   prdata = 32'(vx_r);
      thq_pkg::REG_VERTICES_Z:   prdata = 32'(vz_r);
      thq_pkg::REG_GRID_SPACING: prdata = 32'(sp_r);
      default:                   prdata = '0;
    endcase
  end

  // cell search: column and row with their remainders
  logic          acc;
  logic          xd_vld, zd_vld;
  logic [PW-1:0] col, row;
  logic [SW-1:0] fx, fz;
  logic [AW+HW-1:0] xd_sb;
  logic          zd_sb;

  assign acc = start && !busy;

  thq_div #(.DVD_W(PW), .DSR_W(SW), .QUO_W(PW), .SB_W(AW + HW)) u_xdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc),
    .in_dvd  (in_query_x),
    .divisor (sp_r),
    .in_sb   ({in_vertex_address, in_height_byte}),
    .out_vld (xd_vld),
    .out_quo (col),
    .out_rem (fx),
    .out_sb  (xd_sb)
  );

  thq_div #(.DVD_W(PW), .DSR_W(SW), .QUO_W(PW), .SB_W(1)) u_zdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc),
    .in_dvd  (in_query_z),
    .divisor (sp_r),
    .in_sb   (in_op),
    .out_vld (zd_vld),
    .out_quo (row),
    .out_rem (fz),
    .out_sb  (zd_sb)
  );

  // stage 1: range checks and base address
  logic          s1_vld_r, s1_qry_r, s1_off_r;
  logic [BW-1:0] s1_base_r;
  logic [SW-1:0] s1_fx_r, s1_fz_r;
  logic [AW-1:0] s1_addr_r;
  logic [HW-1:0] s1_byte_r;
  logic          s1_off_nxt;
  logic [PW:0]   col_p1, row_p1;
  logic [2*VW-1:0] row_prod;

  assign col_p1   = {1'b0, col} + 1'b1;
  assign row_p1   = {1'b0, row} + 1'b1;
  assign row_prod = row[VW-1:0] * vx_r;

  always_comb begin
    s1_off_nxt = (sp_r == '0) || (vx_r < VW'(2)) || (vz_r < VW'(2)) ||
                 (32'(vx_r) > thq_pkg::MAX_SIDE) || (32'(vz_r) > thq_pkg::MAX_SIDE) ||
                 (col_p1 >= (PW+1)'(vx_r)) || (row_p1 >= (PW+1)'(vz_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= xd_vld && zd_vld;
    end
    s1_qry_r  <= (zd_sb == thq_pkg::OP_QUERY);
    s1_off_r  <= s1_off_nxt;
    s1_base_r <= BW'(row_prod) + BW'(col[VW-1:0]);
    s1_fx_r   <= fx;
    s1_fz_r   <= fz;
    s1_addr_r <= xd_sb[AW+HW-1:HW];
    s1_byte_r <= xd_sb[HW-1:0];
  end

  // stage 2: far row address, store access
  logic [BW:0]   far_row, far_end;
  logic          s2_vld_r, s2_qry_r, s2_off_r;
  logic [SW-1:0] s2_fx_r, s2_fz_r;
  logic [HW-1:0] smp_d, smp_c, smp_a, smp_b;

  assign far_row = (BW+1)'(s1_base_r) + (BW+1)'(vx_r);
  assign far_end = far_row + 1'b1;

  thq_store u_store (
    .clk     (clk),
    .wr_en   (s1_vld_r && !s1_qry_r),
    .wr_addr (s1_addr_r),
    .wr_data (s1_byte_r),
    .rd_near (s1_base_r[AW-1:0]),
    .rd_far  (far_row[AW-1:0]),
    .smp_d   (smp_d),
    .smp_c   (smp_c),
    .smp_a   (smp_a),
    .smp_b   (smp_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r && s1_qry_r;
    end
    s2_qry_r <= s1_qry_r;
    s2_off_r <= s1_off_r || (far_end >= (BW+1)'(thq_pkg::STORE_DEPTH));
    s2_fx_r  <= s1_fx_r;
    s2_fz_r  <= s1_fz_r;
  end

  // stage 3: triangle pick and weighting products
  logic [SW-1:0]        w, u1, u2;
  logic                 right;
  logic signed [HW:0]   da, db;
  logic                 s3_vld_r, s3_off_r;
  logic [HW+SW-1:0]     s3_p0_r;
  logic signed [HW+SW+1:0] s3_p1_r, s3_p2_r;

  assign w     = sp_r - s2_fz_r;
  assign right = (w < s2_fx_r);

  always_comb begin
    if (right) begin
      da = $signed({1'b0, smp_b}) - $signed({1'b0, smp_a});
      db = $signed({1'b0, smp_c}) - $signed({1'b0, smp_b});
      u1 = s2_fx_r;
      u2 = w;
    end else begin
      da = $signed({1'b0, smp_d}) - $signed({1'b0, smp_a});
      db = $signed({1'b0, smp_c}) - $signed({1'b0, smp_d});
      u1 = w;
      u2 = s2_fx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r && s2_qry_r;
    end
    s3_off_r <= s2_off_r;
    s3_p0_r  <= smp_a * sp_r;
    s3_p1_r  <= da * $signed({1'b0, u1});
    s3_p2_r  <= db * $signed({1'b0, u2});
  end

  // stage 4: plane sum and rounding numerator
  logic signed [NW+3:0] nsum;
  logic [NW-1:0]        nclamp;
  logic [22:0]          hundred_sp;
  logic [DW-1:0]        two_hundred_sp;
  logic                 s4_vld_r, s4_off_r;
  logic [XW-1:0]        s4_x_r;

  assign nsum   = $signed({4'b0, s3_p0_r}) + (NW+4)'(s3_p1_r) + (NW+4)'(s3_p2_r);
  assign nclamp = nsum[NW+3] ? '0 : nsum[NW-1:0];
  assign hundred_sp     = 23'(sp_r) * 23'd100;
  assign two_hundred_sp = DW'(sp_r) * DW'(200);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_off_r <= s3_off_r;
    s4_x_r   <= {1'b0, nclamp, 13'b0} + XW'(hundred_sp);
  end

  // scale to q2.12 with round to nearest
  logic          fd_vld, fd_off;
  logic [QW-1:0] fd_quo;
  logic [DW-1:0] fd_rem;
  logic [DW-1:0] fd_rem_unused;

  thq_div #(.DVD_W(XW), .DSR_W(DW), .QUO_W(QW), .SB_W(1)) u_fdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s4_vld_r),
    .in_dvd  (s4_x_r),
    .divisor (two_hundred_sp),
    .in_sb   (s4_off_r),
    .out_vld (fd_vld),
    .out_quo (fd_quo),
    .out_rem (fd_rem),
    .out_sb  (fd_off)
  );

  assign fd_rem_unused = fd_rem;

  logic                        out_valid_r, out_off_r;
  logic [thq_pkg::SURF_W-1:0]  out_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fd_vld;
    end
    out_off_r <= fd_off;
    out_h_r   <= fd_off ? '0 : (fd_quo + thq_pkg::HALF_Q12);
  end

  assign out_valid          = out_valid_r;
  assign out_surface_height = out_h_r;
  assign out_off_grid       = out_off_r;

endmodule
`default_nettype wire
